[rtl/core/salsa_pkg.sv]
// shared types, constants and helper functions of the salsa20 keystream block
package salsa_pkg;

	// sixteen 32-bit state words, word 0 in the lowest bits
	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0] widx_t;

	// one pipeline slot: working state plus the block counter it was built from
	typedef struct packed {
		state_t      state;
		logic [63:0] ctr;
	} stage_t;

	// configuration register indexes
	localparam logic [2:0] CFG_KEY0  = 3'd0;
	localparam logic [2:0] CFG_KEY1  = 3'd1;
	localparam logic [2:0] CFG_KEY2  = 3'd2;
	localparam logic [2:0] CFG_KEY3  = 3'd3;
	localparam logic [2:0] CFG_NONCE = 3'd4;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	// output tdata: word_index, keystream_word, zero fill to whole bytes
	localparam int OUT_TDATA_W = 40;

	// rotate left by a constant amount
	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// rotate amount of quarter-round sub-step s
	function automatic int unsigned rot_amt(input int s);
		int unsigned r;
		case (s)
			0: r = 7;
			1: r = 9;
			2: r = 13;
			default: r = 18;
		endcase
		return r;
	endfunction

	// word index of position p (a, b, c, d) in quarter q of a column (h=0) or row (h=1) round
	function automatic widx_t qr_idx(input int h, input int q, input int p);
		logic [15:0] grp;
		logic [2:0]  sel;
		sel = {h[0], q[1:0]};
		case (sel)
			3'd0: grp = 16'hC840;
			3'd1: grp = 16'h1D95;
			3'd2: grp = 16'h62EA;
			3'd3: grp = 16'hB73F;
			3'd4: grp = 16'h3210;
			3'd5: grp = 16'h4765;
			3'd6: grp = 16'h98BA;
			default: grp = 16'hEDCF;
		endcase
		return grp[p*4 +: 4];
	endfunction

	// standard initial state from key, nonce and counter
	function automatic state_t init_state(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] n,
			input logic [63:0] ctr);
		state_t s;
		s[0]  = SIGMA0;
		s[1]  = k0[31:0];
		s[2]  = k0[63:32];
		s[3]  = k1[31:0];
		s[4]  = k1[63:32];
		s[5]  = SIGMA1;
		s[6]  = n[31:0];
		s[7]  = n[63:32];
		s[8]  = ctr[31:0];
		s[9]  = ctr[63:32];
		s[10] = SIGMA2;
		s[11] = k2[31:0];
		s[12] = k2[63:32];
		s[13] = k3[31:0];
		s[14] = k3[63:32];
		s[15] = SIGMA3;
		return s;
	endfunction

endpackage

[rtl/core/salsa20_keystream_block.sv]
// salsa20 keystream block top level: config registers, round pipeline, final add, serializer
// block path: round stages, final-add register, serializer buffer, one-word output channel
// one round stage per quarter-round sub-step, so the pipeline can take a counter every cycle
// while no block waits on the serializer, which takes a new block as its last word is sent
// reset: asynchronous active low, clears key, nonce, valid bits and the serializer
module salsa20_keystream_block #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [63:0]                       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [63:0]                       s_tdata,   // [63:0] block_counter
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [salsa_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] word_index, [35:4] keystream_word
	output logic                              m_tlast
);
	import salsa_pkg::*;

	localparam int NSTEP = DOUBLE_ROUNDS * 8;

	logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
	logic        en;
	logic        ser_ready;
	stage_t      stg [0:NSTEP];
	logic        vld [0:NSTEP];
	state_t      add_words_s2;
	logic        add_valid_s2;
	state_t      init_fin;

	// configuration registers, out-of-range index ignored
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= 64'd0;
			key1_q  <= 64'd0;
			key2_q  <= 64'd0;
			key3_q  <= 64'd0;
			nonce_q <= 64'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY0:  key0_q  <= cfg_data;
				CFG_KEY1:  key1_q  <= cfg_data;
				CFG_KEY2:  key2_q  <= cfg_data;
				CFG_KEY3:  key3_q  <= cfg_data;
				CFG_NONCE: nonce_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances together unless the finished block cannot be handed off
	assign en       = !add_valid_s2 || ser_ready;
	assign s_tready = en;

	// pipeline entry: build the initial state
	assign vld[0]       = s_tvalid;
	assign stg[0].ctr   = s_tdata;
	assign stg[0].state = init_state(key0_q, key1_q, key2_q, key3_q, nonce_q, s_tdata);

	// round stages
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		salsa_step #(.STEP(k % 8)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld[k]),
			.in_stage (stg[k]),
			.out_valid(vld[k+1]),
			.out_stage(stg[k+1])
		);
	end

	// feed-forward add of the original state
	assign init_fin = init_state(key0_q, key1_q, key2_q, key3_q, nonce_q, stg[NSTEP].ctr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_valid_s2 <= 1'b0;
		end else if (en) begin
			add_valid_s2 <= vld[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < 16; w++) begin
				add_words_s2[w] <= stg[NSTEP].state[w] + init_fin[w];
			end
		end
	end

	// word-by-word output
	salsa_ser u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(add_valid_s2),
		.in_words(add_words_s2),
		.in_ready(ser_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	// words of a block come out in index order
	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)))
		else $error("word index did not advance");

	// tlast marks exactly the sixteenth word
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'hF)))
		else $error("tlast and word index disagree");

	// input stalls only while a block is waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with idle output");
`endif

endmodule

[rtl/core/salsa_step.sv]
// one pipeline stage: one add-rotate-xor sub-step of four quarter-rounds in parallel
module salsa_step #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  salsa_pkg::stage_t in_stage,
	output logic              out_valid,
	output salsa_pkg::stage_t out_stage
);
	import salsa_pkg::*;

	// sub-step within the quarter-round and column/row half of the double round
	localparam int SUB  = STEP % 4;
	localparam int HALF = STEP / 4;

	stage_t nxt;

	// target word ^= rotl(src1 + src2) for each of the four quarters
	always_comb begin
		nxt = in_stage;
		for (int q = 0; q < 4; q++) begin
			nxt.state[qr_idx(HALF, q, (SUB + 1) % 4)] =
				in_stage.state[qr_idx(HALF, q, (SUB + 1) % 4)] ^
				rotl32(in_stage.state[qr_idx(HALF, q, SUB)] +
					in_stage.state[qr_idx(HALF, q, (SUB + 3) % 4)], rot_amt(SUB));
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			out_stage <= nxt;
		end
	end

endmodule

[rtl/core/salsa_ser.sv]
// output serializer: holds one finished block and sends its sixteen words
module salsa_ser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  salsa_pkg::state_t                   in_words,
	output logic                                in_ready,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [salsa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [3:0] word_index, [35:4] keystream_word
	output logic                                m_tlast
);
	import salsa_pkg::*;

	state_t      blk_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        last_xfer;

	assign last_xfer = busy_q && m_tready && (cnt_q == 4'hF);
	assign in_ready  = !busy_q || last_xfer;

	// word counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd0;
		end else if (busy_q && m_tready) begin
			busy_q <= (cnt_q != 4'hF);
			cnt_q  <= cnt_q + 4'd1;
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_q <= in_words;
		end
	end

	// output word select
	assign m_tvalid = busy_q;
	assign m_tdata  = {4'd0, blk_q[cnt_q], cnt_q};
	assign m_tlast  = (cnt_q == 4'hF);

endmodule
